// ===== hw/rtl/mtbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtbr_pkg;

  localparam logic [9:0]  STATE_WORDS  = 10'd624;
  localparam logic [9:0]  LAST_WORD    = 10'd623;
  localparam logic [9:0]  TWIST_OFFSET = 10'd397;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
  localparam logic [31:0] SEED_MULT    = 32'd1812433253;
  localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_FILL0,
    S_FILL_MUL,
    S_FILL_WR,
    S_IDLE,
    S_SCALE,
    S_LIMIT,
    S_RD0,
    S_RD1,
    S_RD2,
    S_TWIST,
    S_TEMPER,
    S_CHECK,
    S_QUOT,
    S_OUT
  } state_e;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] r;
    r = x ^ (x >> 11);
    r = r ^ ((r << 7) & TEMPER_B);
    r = r ^ ((r << 15) & TEMPER_C);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mtbr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtbr_ram (
  input  wire logic        clk_i,
  input  wire logic        we_i,
  input  wire logic [9:0]  waddr_i,
  input  wire logic [31:0] wdata_i,
  input  wire logic [9:0]  raddr_i,
  output logic      [31:0] rdata_o
);

  logic [31:0] mem [624];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mtbr_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mtbr_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic      [31:0] quotient_o
);

  logic [31:0] quo_q, quo_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] shifted;
  logic [33:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[31]};
    diff    = {1'b0, shifted} - {2'b00, dsr_q};
    quo_d   = quo_q;
    rem_d   = rem_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[33]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");
  a_no_restart_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_count_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0)
    else $error("divider busy with zero count");

endmodule

`default_nettype wire

// ===== hw/rtl/mt19937_bounded_random.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                | Payload
// ----------+--------------------------+---------------------------------------------
// cfg       | cfg_valid_i / cfg_ready_o | cfg_seed_i
// request   | in_valid_i / in_ready_o   | req_type_i, range_low_i, range_high_i
// result    | out_valid_o / out_ready_i | raw_word_o, bounded_value_o, range_error_o
//
// Raw request: three state RAM reads, twist write, temper, check.
// Bounded request: a divide for the scale, a multiply for the limit, one draw per
// attempt including rejected ones, then a divide for the quotient; a full range
// skips both divides and an inverted range goes straight to an error result.
// Reset and every seed write run a fill of the state RAM; no request is taken meanwhile.
// A waiting result sits in the output register; the next request is taken.
module mt19937_bounded_random (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [31:0] cfg_seed_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               req_type_i,
  input  wire logic signed [31:0] range_low_i,
  input  wire logic signed [31:0] range_high_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [31:0] raw_word_o,
  output logic signed      [31:0] bounded_value_o,
  output logic                    range_error_o
);

  mtbr_pkg::state_e state_q, state_d;

  logic [31:0] seed_q, seed_d;
  logic [9:0]  pos_q, pos_d, fidx_q, fidx_d;
  logic [31:0] prev_q, prev_d, prod_q, prod_d;
  logic        req_q, req_d, full_q, full_d;
  logic [31:0] lo_q, lo_d, range_q, range_d, scale_q, scale_d, limit_q, limit_d;
  logic [31:0] wpos_q, wpos_d, wnxt_q, wnxt_d, twist_q, twist_d, raw_q, raw_d;
  logic [31:0] bnd_q, bnd_d;
  logic        err_q, err_d;
  logic        ovalid_q, ovalid_d;
  logic [31:0] oraw_q, oraw_d, obnd_q, obnd_d;
  logic        oerr_q, oerr_d;

  logic        ram_we;
  logic [9:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic        div_start, div_done;
  logic [31:0] div_dend, div_sor, div_quo;

  logic [9:0]  nxt_idx, far_idx;
  logic [10:0] far_sum;
  logic [31:0] mixed, twisted, fill_word, in_range;

  mtbr_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mtbr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dend),
    .divisor_i  (div_sor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign nxt_idx   = (pos_q == mtbr_pkg::LAST_WORD) ? 10'd0 : pos_q + 10'd1;
  assign far_sum   = {1'b0, pos_q} + {1'b0, mtbr_pkg::TWIST_OFFSET};
  assign far_idx   = (far_sum >= {1'b0, mtbr_pkg::STATE_WORDS})
                     ? 10'(far_sum - {1'b0, mtbr_pkg::STATE_WORDS}) : far_sum[9:0];
  assign mixed     = {wpos_q[31], wnxt_q[30:0]};
  assign twisted   = ram_rdata ^ (mixed >> 1) ^ (wnxt_q[0] ? mtbr_pkg::TWIST_MATRIX : '0);
  assign fill_word = prod_q + {22'd0, fidx_q};
  assign in_range  = 32'(range_high_i) - 32'(range_low_i) + 32'd1;

  // a seed write takes priority over a request
  assign in_ready_o  = (state_q == mtbr_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == mtbr_pkg::S_IDLE);

  always_comb begin
    state_d   = state_q;
    seed_d    = seed_q;
    pos_d     = pos_q;
    fidx_d    = fidx_q;
    prev_d    = prev_q;
    prod_d    = prod_q;
    req_d     = req_q;
    full_d    = full_q;
    lo_d      = lo_q;
    range_d   = range_q;
    scale_d   = scale_q;
    limit_d   = limit_q;
    wpos_d    = wpos_q;
    wnxt_d    = wnxt_q;
    twist_d   = twist_q;
    raw_d     = raw_q;
    bnd_d     = bnd_q;
    err_d     = err_q;
    ovalid_d  = ovalid_q & ~out_ready_i;
    oraw_d    = oraw_q;
    obnd_d    = obnd_q;
    oerr_d    = oerr_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = twisted;
    ram_raddr = pos_q;
    div_start = 1'b0;
    div_dend  = mtbr_pkg::ALL_ONES;
    div_sor   = range_q;

    unique case (state_q)
      mtbr_pkg::S_FILL0: begin
        ram_we    = 1'b1;
        ram_waddr = 10'd0;
        ram_wdata = seed_q;
        prev_d    = seed_q;
        fidx_d    = 10'd1;
        state_d   = mtbr_pkg::S_FILL_MUL;
      end
      mtbr_pkg::S_FILL_MUL: begin
        prod_d  = 32'(mtbr_pkg::SEED_MULT * (prev_q ^ (prev_q >> 30)));
        state_d = mtbr_pkg::S_FILL_WR;
      end
      mtbr_pkg::S_FILL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = fidx_q;
        ram_wdata = fill_word;
        prev_d    = fill_word;
        fidx_d    = fidx_q + 10'd1;
        if (fidx_q == mtbr_pkg::LAST_WORD) begin
          pos_d   = mtbr_pkg::STATE_WORDS;
          state_d = mtbr_pkg::S_IDLE;
        end else begin
          state_d = mtbr_pkg::S_FILL_MUL;
        end
      end
      mtbr_pkg::S_IDLE: begin
        if (cfg_valid_i) begin
          seed_d  = cfg_seed_i;
          state_d = mtbr_pkg::S_FILL0;
        end else if (in_valid_i) begin
          req_d   = req_type_i;
          lo_d    = 32'(range_low_i);
          range_d = in_range;
          full_d  = (in_range == 32'd0);
          raw_d   = '0;
          bnd_d   = '0;
          err_d   = 1'b0;
          if (!req_type_i) begin
            state_d = mtbr_pkg::S_RD0;
          end else if (range_high_i < range_low_i) begin
            err_d   = 1'b1;
            state_d = mtbr_pkg::S_OUT;
          end else if (in_range == 32'd0) begin
            state_d = mtbr_pkg::S_RD0;
          end else begin
            div_start = 1'b1;
            div_sor   = in_range;
            state_d   = mtbr_pkg::S_SCALE;
          end
        end
      end
      mtbr_pkg::S_SCALE: begin
        if (div_done) begin
          scale_d = div_quo;
          state_d = mtbr_pkg::S_LIMIT;
        end
      end
      mtbr_pkg::S_LIMIT: begin
        limit_d = 32'(range_q * scale_q);
        state_d = mtbr_pkg::S_RD0;
      end
      mtbr_pkg::S_RD0: begin
        if (pos_q >= mtbr_pkg::STATE_WORDS) begin
          pos_d     = 10'd0;
          ram_raddr = 10'd0;
        end
        state_d = mtbr_pkg::S_RD1;
      end
      mtbr_pkg::S_RD1: begin
        wpos_d    = ram_rdata;
        ram_raddr = nxt_idx;
        state_d   = mtbr_pkg::S_RD2;
      end
      mtbr_pkg::S_RD2: begin
        wnxt_d    = ram_rdata;
        ram_raddr = far_idx;
        state_d   = mtbr_pkg::S_TWIST;
      end
      mtbr_pkg::S_TWIST: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = twisted;
        twist_d   = twisted;
        pos_d     = pos_q + 10'd1;
        state_d   = mtbr_pkg::S_TEMPER;
      end
      mtbr_pkg::S_TEMPER: begin
        raw_d   = mtbr_pkg::temper(twist_q);
        state_d = mtbr_pkg::S_CHECK;
      end
      mtbr_pkg::S_CHECK: begin
        if (!req_q) begin
          state_d = mtbr_pkg::S_OUT;
        end else if (full_q) begin
          bnd_d   = lo_q + raw_q;
          state_d = mtbr_pkg::S_OUT;
        end else if (raw_q >= limit_q) begin
          state_d = mtbr_pkg::S_RD0;
        end else begin
          div_start = 1'b1;
          div_dend  = raw_q;
          div_sor   = scale_q;
          state_d   = mtbr_pkg::S_QUOT;
        end
      end
      mtbr_pkg::S_QUOT: begin
        div_sor = scale_q;
        if (div_done) begin
          bnd_d   = lo_q + div_quo;
          state_d = mtbr_pkg::S_OUT;
        end
      end
      mtbr_pkg::S_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          oraw_d   = raw_q;
          obnd_d   = bnd_q;
          oerr_d   = err_q;
          state_d  = mtbr_pkg::S_IDLE;
        end
      end
      default: state_d = mtbr_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mtbr_pkg::S_FILL0;
      seed_q   <= '0;
      pos_q    <= mtbr_pkg::STATE_WORDS;
      fidx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seed_q   <= seed_d;
      pos_q    <= pos_d;
      fidx_q   <= fidx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q  <= prev_d;
    prod_q  <= prod_d;
    req_q   <= req_d;
    full_q  <= full_d;
    lo_q    <= lo_d;
    range_q <= range_d;
    scale_q <= scale_d;
    limit_q <= limit_d;
    wpos_q  <= wpos_d;
    wnxt_q  <= wnxt_d;
    twist_q <= twist_d;
    raw_q   <= raw_d;
    bnd_q   <= bnd_d;
    err_q   <= err_d;
    oraw_q  <= oraw_d;
    obnd_q  <= obnd_d;
    oerr_q  <= oerr_d;
  end

  assign out_valid_o     = ovalid_q;
  assign raw_word_o      = oraw_q;
  assign bounded_value_o = obnd_q;
  assign range_error_o   = oerr_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && oerr_q) |-> (oraw_q == 32'd0 && obnd_q == 32'd0))
    else $error("range error result carries a nonzero word");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtbr_pkg::S_IDLE) |-> !ram_we)
    else $error("state RAM written while idle");
  a_twist_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtbr_pkg::S_TWIST) |-> pos_q < mtbr_pkg::STATE_WORDS)
    else $error("twist at an out-of-range position");
  a_reject_redraw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtbr_pkg::S_CHECK && req_q && !full_q && raw_q >= limit_q)
    |=> state_q == mtbr_pkg::S_RD0)
    else $error("rejected word did not cause a redraw");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_WORDS   = 624;
  localparam int TWIST_SKIP  = 397;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic {REQ_RAW = 1'b0, REQ_BOUNDED = 1'b1} req_kind_e;

  typedef struct packed {
    logic [31:0]        raw;
    logic signed [31:0] bounded;
    logic               err;
  } draw_result_t;

  typedef struct {
    req_kind_e          kind;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    bit                 known;
    draw_result_t       res;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [31:0] cfg_seed_i;
  logic in_valid_i, in_ready_o;
  logic req_type_i;
  logic signed [31:0] range_low_i, range_high_i;
  logic out_valid_o, out_ready_i;
  logic [31:0] raw_word_o;
  logic signed [31:0] bounded_value_o;
  logic range_error_o;

  mt19937_bounded_random u_top (.*);

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] mt_words [NUM_WORDS];
  int unsigned mt_pos;
  int unsigned draws_since_seed;
  draw_result_t pending_draws[$];
  int mismatch_count;
  bit timed_out;
  int cycle_count;
  int send_idle_pct, recv_idle_pct;

  function automatic void seed_words(input logic [31:0] s);
    logic [31:0] prev;
    mt_words[0] = s;
    for (int i = 1; i < NUM_WORDS; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = 32'd1812433253 * (prev ^ (prev >> 30)) + i;
    end
    mt_pos = NUM_WORDS;
    draws_since_seed = 0;
  endfunction

  function automatic logic [31:0] next_tempered();
    int unsigned p, nx, fr;
    logic [31:0] mixed, r;
    if (mt_pos >= NUM_WORDS) mt_pos = 0;
    p = mt_pos;
    nx = (p + 1) % NUM_WORDS;
    fr = (p + TWIST_SKIP) % NUM_WORDS;
    mixed = (mt_words[p] & 32'h8000_0000) | (mt_words[nx] & 32'h7FFF_FFFF);
    r = mt_words[fr] ^ (mixed >> 1) ^ (mt_words[nx][0] ? 32'h9908_B0DF : 32'h0);
    mt_words[p] = r;
    mt_pos = p + 1;
    draws_since_seed++;
    r ^= r >> 11;
    r ^= (r << 7) & 32'h9D2C_5680;
    r ^= (r << 15) & 32'hEFC6_0000;
    r ^= r >> 18;
    return r;
  endfunction

  function automatic draw_result_t predict_draw(input req_kind_e kind,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi);
    draw_result_t d;
    logic [31:0] span, scale, limit;
    d = '0;
    if (kind == REQ_RAW) begin
      d.raw = next_tempered();
    end else if (hi < lo) begin
      d.err = 1'b1;
    end else begin
      span = hi - lo + 32'd1;
      if (span == 0) begin
        d.raw = next_tempered();
        d.bounded = lo + d.raw;
      end else begin
        scale = 32'hFFFF_FFFF / span;
        limit = span * scale;
        do d.raw = next_tempered(); while (d.raw >= limit);
        d.bounded = lo + d.raw / scale;
      end
    end
    return d;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_draws.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result raw=%h", raw_word_o);
      end else begin
        draw_result_t e;
        e = pending_draws.pop_front();
        if (e.raw !== raw_word_o || e.bounded !== bounded_value_o
            || e.err !== range_error_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp raw=%h val=%0d err=%b, got raw=%h val=%0d err=%b",
                     e.raw, e.bounded, e.err, raw_word_o, bounded_value_o, range_error_o);
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("testbench: errors");
      $finish;
    end
  end

  // valid stays high after the request until the next one or release_input
  task automatic send_request(input req_kind_e kind, input logic signed [31:0] lo,
                              input logic signed [31:0] hi);
    draw_result_t exp_d;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      req_type_i <= 1'($urandom_range(1));
      range_low_i <= $urandom;
      range_high_i <= $urandom;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    range_low_i <= lo;
    range_high_i <= hi;
    do @(posedge clk_i); while (!in_ready_o);
    exp_d = predict_draw(kind, lo, hi);
    pending_draws = {pending_draws, exp_d};
    @(negedge clk_i);
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    req_type_i <= 1'($urandom_range(1));
    range_low_i <= $urandom;
    range_high_i <= $urandom;
  endtask

  task automatic write_seed(input logic [31:0] s);
    release_input();
    wait (pending_draws.size() == 0);
    repeat (200) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_seed_i <= s;
    do @(posedge clk_i); while (!cfg_ready_o);
    seed_words(s);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_request();
    logic signed [31:0] lo, hi;
    int sel;
    sel = $urandom_range(9);
    lo = $urandom;
    hi = $urandom;
    case (sel)
      0, 1, 2: send_request(REQ_RAW, lo, hi);
      3, 4: begin
        hi = lo + $urandom_range(20);
        if (hi < lo) hi = lo;
        send_request(REQ_BOUNDED, lo, hi);
      end
      5: send_request(REQ_BOUNDED, lo, hi);  // any order, errors included
      6: begin
        // ranges just above half the word space force many redraws; if hi wraps below lo the range is lo alone
        lo = $urandom_range(1000) - 500;
        hi = lo + 32'h8000_0000 + $urandom_range(1000);
        if (hi < lo) hi = lo;
        send_request(REQ_BOUNDED, lo, hi);
      end
      7: send_request(REQ_BOUNDED, 32'sh8000_0000, 32'sh7FFF_FFFF);
      default: begin
        if (lo > hi) begin
          logic signed [31:0] t;
          t = lo; lo = hi; hi = t;
        end
        send_request(REQ_BOUNDED, lo, hi);
      end
    endcase
  endtask

  stim_row_t dir_rows[$];

  initial begin
    stim_row_t row;
    draw_result_t got;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_seed_i = '0;
    in_valid_i = 1'b0;
    req_type_i = 1'b0;
    range_low_i = '0;
    range_high_i = '0;
    mismatch_count = 0;
    timed_out = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    seed_words(32'd0);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // kind, lo, hi, known, expected {raw, bounded, err}
    dir_rows = '{
      '{REQ_RAW, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
      '{REQ_BOUNDED, 32'sd5, 32'sd4, 1'b1, '{32'd0, 32'sd0, 1'b1}},
      '{REQ_BOUNDED, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, '{32'd0, 32'sd0, 1'b1}},
      '{REQ_BOUNDED, 32'sd7, 32'sd7, 1'b0, '0},
      '{REQ_BOUNDED, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '0},
      '{REQ_BOUNDED, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, '0},
      '{REQ_BOUNDED, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, '0},
      '{REQ_BOUNDED, 32'sh8000_0000, 32'sh7FFF_FFFE, 1'b0, '0},
      '{REQ_BOUNDED, -32'sd1, 32'sd0, 1'b0, '0},
      '{REQ_BOUNDED, 32'sd0, 32'sh4000_0000, 1'b0, '0},
      '{REQ_BOUNDED, -32'sd10, 32'sd10, 1'b0, '0},
      '{REQ_RAW, 32'sd0, 32'sd0, 1'b0, '0},
      '{REQ_RAW, -32'sd1, -32'sd1, 1'b0, '0}
    };
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.kind, row.lo, row.hi);
      if (row.known) begin
        got = pending_draws[$];
        if (got !== row.res) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("predictor disagrees on directed row %0d", i);
        end
      end
    end

    // about two draws per request; runs until the position has wrapped
    write_seed(32'hFFFF_FFFF);
    while (draws_since_seed < 650)
      send_request(REQ_BOUNDED, -32'sh4000_0000, 32'sh4000_0000);

    write_seed(32'd5489);
    send_idle_pct = 20;
    recv_idle_pct = 83;
    for (int i = 0; i < 60; i++) random_request();
    write_seed($urandom);
    send_idle_pct = 83;
    recv_idle_pct = 20;
    for (int i = 0; i < 60; i++) random_request();
    write_seed(32'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 60; i++) random_request();

    release_input();
    wait (pending_draws.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && pending_draws.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
